// ----- hw/rtl/nosc_pkg.sv -----
// Natural-order string comparator: shared types, constants and helpers.
// Used by nosc_ctrl, nosc_datapath and natural_order_string_compare.
`timescale 1ns / 1ps

package nosc_pkg;

    localparam int CHAR_W = 16;

    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 16'h0030;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 16'h0039;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_RUN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // input transfer: store the units of this position
        logic step;         // advance both pointers by one unit
        logic run_init;     // clear both digit-run accumulators
        logic run_step;     // fold one digit into each active run
        logic finish;       // load the result register, clear lengths and pointers
        logic result_less;  // result to load with finish
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exhausted;    // either pointer has reached its length
        logic right_left;   // right pointer still below right length
        logic left_digit;
        logic right_digit;
        logic char_lt;
        logic char_gt;
        logic run_busy;     // at least one side still takes digits
        logic run_lt;
        logic run_gt;
        logic out_valid;    // result register holds an untaken result
    } status_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
    endfunction

endpackage

// ----- hw/rtl/nosc_ctrl.sv -----
// Controller of the natural-order string comparator: load, walk and run states.
// Depends on nosc_pkg.
`timescale 1ns / 1ps

module nosc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  logic              m_tready,
    input  nosc_pkg::status_t status,
    output nosc_pkg::cmd_t    cmd
);

    nosc_pkg::state_t state_reg;
    nosc_pkg::state_t state_next;
    logic             out_free;

    assign out_free = !status.out_valid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nosc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            nosc_pkg::ST_IDLE: begin
                // hold off the closing transfer until the result register is free
                s_tready = !s_tlast || out_free;
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = nosc_pkg::ST_START;
                    end
                end
            end
            nosc_pkg::ST_START: begin
                // first units are being read out of the buffers
                state_next = nosc_pkg::ST_WALK;
            end
            nosc_pkg::ST_WALK: begin
                priority if (status.exhausted) begin
                    cmd.finish      = 1'b1;
                    cmd.result_less = status.right_left;
                end else if (status.left_digit && status.right_digit) begin
                    cmd.run_init = 1'b1;
                end else if (status.left_digit) begin
                    cmd.finish      = 1'b1;
                    cmd.result_less = 1'b1;
                end else if (status.right_digit) begin
                    cmd.finish = 1'b1;
                end else if (status.char_lt) begin
                    cmd.finish      = 1'b1;
                    cmd.result_less = 1'b1;
                end else if (status.char_gt) begin
                    cmd.finish = 1'b1;
                end else begin
                    cmd.step = 1'b1;
                end
                if (cmd.finish) begin
                    state_next = nosc_pkg::ST_IDLE;
                end else if (cmd.run_init) begin
                    state_next = nosc_pkg::ST_RUN;
                end
            end
            nosc_pkg::ST_RUN: begin
                priority if (status.run_busy) begin
                    cmd.run_step = 1'b1;
                end else if (status.run_lt) begin
                    cmd.finish      = 1'b1;
                    cmd.result_less = 1'b1;
                    state_next      = nosc_pkg::ST_IDLE;
                end else if (status.run_gt) begin
                    cmd.finish = 1'b1;
                    state_next = nosc_pkg::ST_IDLE;
                end else begin
                    state_next = nosc_pkg::ST_WALK;
                end
            end
            default: begin
                state_next = nosc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/nosc_datapath.sv -----
// Datapath of the natural-order string comparator: string buffers, lengths,
// walk pointers, digit-run accumulators and the result register. Depends on nosc_pkg.
`timescale 1ns / 1ps

module nosc_datapath #(
    parameter int MAX_LEN        = 32,
    parameter int MAX_RUN_DIGITS = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nosc_pkg::cmd_t                cmd,
    input  logic [nosc_pkg::CHAR_W-1:0]   in_left_char,
    input  logic                          in_left_valid,
    input  logic [nosc_pkg::CHAR_W-1:0]   in_right_char,
    input  logic                          in_right_valid,
    input  logic                          m_tready,
    output nosc_pkg::status_t             status,
    output logic                          out_left_is_less,
    output logic                          out_length_overflow
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    // bits for 10**MAX_RUN_DIGITS - 1 (log2 10 rounded up slightly)
    localparam int VAL_W = (MAX_RUN_DIGITS * 3322 + 999) / 1000;
    localparam int SIG_W = $clog2(MAX_RUN_DIGITS + 1);

    logic [nosc_pkg::CHAR_W-1:0] lbuf_mem [MAX_LEN];
    logic [nosc_pkg::CHAR_W-1:0] rbuf_mem [MAX_LEN];

    logic [LEN_W-1:0] llen_reg, llen_next, rlen_reg, rlen_next;
    logic [LEN_W-1:0] lptr_reg, lptr_next, rptr_reg, rptr_next;
    logic             ovf_reg, ovf_next;
    logic [nosc_pkg::CHAR_W-1:0] lch_reg, rch_reg;
    logic [IDX_W-1:0] lrd_addr, rrd_addr;
    logic             lwr_en, rwr_en, lfull, rfull;

    logic [VAL_W-1:0] lval_reg, lval_next, rval_reg, rval_next;
    logic [VAL_W-1:0] lval_step, rval_step;
    logic [SIG_W-1:0] lsig_reg, lsig_next, rsig_reg, rsig_next;
    logic             lact, ract, lin, rin;

    logic out_valid_reg, out_valid_next;
    logic out_less_reg, out_less_next;
    logic out_ovf_reg, out_ovf_next;

    assign lfull  = (llen_reg >= LEN_W'(MAX_LEN));
    assign rfull  = (rlen_reg >= LEN_W'(MAX_LEN));
    assign lwr_en = cmd.load && in_left_valid && !lfull;
    assign rwr_en = cmd.load && in_right_valid && !rfull;

    // read data always belongs to the pointer value of the coming cycle
    assign lrd_addr = (lptr_next < LEN_W'(MAX_LEN)) ? lptr_next[IDX_W-1:0] : '0;
    assign rrd_addr = (rptr_next < LEN_W'(MAX_LEN)) ? rptr_next[IDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (lwr_en) begin
            lbuf_mem[llen_reg[IDX_W-1:0]] <= in_left_char;
        end
        lch_reg <= lbuf_mem[lrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (rwr_en) begin
            rbuf_mem[rlen_reg[IDX_W-1:0]] <= in_right_char;
        end
        rch_reg <= rbuf_mem[rrd_addr];
    end

    assign lin  = (lptr_reg < llen_reg);
    assign rin  = (rptr_reg < rlen_reg);
    assign lact = lin && nosc_pkg::is_digit(lch_reg) && (lsig_reg < SIG_W'(MAX_RUN_DIGITS));
    assign ract = rin && nosc_pkg::is_digit(rch_reg) && (rsig_reg < SIG_W'(MAX_RUN_DIGITS));

    // value * 10 + digit; the digit is the low nibble of an ASCII digit
    assign lval_step = (lval_reg << 3) + (lval_reg << 1) + VAL_W'(lch_reg[3:0]);
    assign rval_step = (rval_reg << 3) + (rval_reg << 1) + VAL_W'(rch_reg[3:0]);

    always_comb begin
        llen_next = llen_reg;
        rlen_next = rlen_reg;
        ovf_next  = ovf_reg;
        lptr_next = lptr_reg;
        rptr_next = rptr_reg;
        lval_next = lval_reg;
        rval_next = rval_reg;
        lsig_next = lsig_reg;
        rsig_next = rsig_reg;

        if (lwr_en) begin
            llen_next = llen_reg + 1'b1;
        end
        if (rwr_en) begin
            rlen_next = rlen_reg + 1'b1;
        end
        if (cmd.load && ((in_left_valid && lfull) || (in_right_valid && rfull))) begin
            ovf_next = 1'b1;
        end

        if (cmd.step) begin
            lptr_next = lptr_reg + 1'b1;
            rptr_next = rptr_reg + 1'b1;
        end

        if (cmd.run_init) begin
            lval_next = '0;
            rval_next = '0;
            lsig_next = '0;
            rsig_next = '0;
        end
        if (cmd.run_step && lact) begin
            lval_next = lval_step;
            lptr_next = lptr_reg + 1'b1;
            if ((lval_reg != '0) || (lch_reg[3:0] != 4'd0)) begin
                lsig_next = lsig_reg + 1'b1;
            end
        end
        if (cmd.run_step && ract) begin
            rval_next = rval_step;
            rptr_next = rptr_reg + 1'b1;
            if ((rval_reg != '0) || (rch_reg[3:0] != 4'd0)) begin
                rsig_next = rsig_reg + 1'b1;
            end
        end

        // drop the pair once its result is taken into the output register
        if (cmd.finish) begin
            llen_next = '0;
            rlen_next = '0;
            ovf_next  = 1'b0;
            lptr_next = '0;
            rptr_next = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_less_next  = out_less_reg;
        out_ovf_next   = out_ovf_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
            out_less_next  = cmd.result_less;
            out_ovf_next   = ovf_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            llen_reg      <= '0;
            rlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            lptr_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            llen_reg      <= llen_next;
            rlen_reg      <= rlen_next;
            ovf_reg       <= ovf_next;
            lptr_reg      <= lptr_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lval_reg     <= lval_next;
        rval_reg     <= rval_next;
        lsig_reg     <= lsig_next;
        rsig_reg     <= rsig_next;
        out_less_reg <= out_less_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb begin
        status.exhausted   = !lin || !rin;
        status.right_left  = rin;
        status.left_digit  = nosc_pkg::is_digit(lch_reg);
        status.right_digit = nosc_pkg::is_digit(rch_reg);
        status.char_lt     = (lch_reg < rch_reg);
        status.char_gt     = (lch_reg > rch_reg);
        status.run_busy    = lact || ract;
        status.run_lt      = (lval_reg < rval_reg);
        status.run_gt      = (lval_reg > rval_reg);
        status.out_valid   = out_valid_reg;
    end

    assign out_left_is_less    = out_less_reg;
    assign out_length_overflow = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (llen_reg <= LEN_W'(MAX_LEN)) && (rlen_reg <= LEN_W'(MAX_LEN)))
        else $error("string length beyond buffer depth");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (lptr_reg <= llen_reg) && (rptr_reg <= rlen_reg))
        else $error("walk pointer beyond stored length");
`endif

endmodule

// ----- hw/rtl/natural_order_string_compare.sv -----
// Natural-order string comparator: top level joining controller and datapath.
// Depends on nosc_pkg, nosc_ctrl and nosc_datapath.
//
// Usage:
//   Input stream (s_): one transfer per string position, carrying one UTF-16
//   code unit of the left and of the right string with a presence flag each.
//   Positions are taken one per cycle while s_tready is high. Units beyond
//   MAX_LEN per string are dropped and reported as length overflow. tlast
//   marks the final position. Output stream (m_): one transfer per pair,
//   after the final position: left_is_less (1 = left sorts strictly before
//   right) and length_overflow. Processing: after the final transfer the
//   buffers are read out, then the walk steps over each matched non-digit
//   unit, opens each digit run, takes the digits of the longer run of the
//   pair one at a time and compares the runs; each string buffer has a
//   single read port. During that walk s_tready is low.
//   The result waits in an output register; loading of the next pair goes on
//   while it waits, only its final transfer is held until the result is taken.
//   Reset (aresetn low, synchronous) empties both strings, clears the
//   overflow flag and drops any pending result.
`timescale 1ns / 1ps

module natural_order_string_compare #(
    parameter int MAX_LEN        = 32,
    parameter int MAX_RUN_DIGITS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] left_char, [31:16] right_char
    input  logic [1:0]  s_tuser,   // [0] left_valid, [1] right_valid
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] left_is_less, [7:1] zero
    output logic [0:0]  m_tuser    // [0] length_overflow
);

    nosc_pkg::cmd_t    cmd;
    nosc_pkg::status_t status;
    logic              left_is_less;
    logic              length_overflow;

    nosc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nosc_datapath #(
        .MAX_LEN        (MAX_LEN),
        .MAX_RUN_DIGITS (MAX_RUN_DIGITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .in_left_char        (s_tdata[15:0]),
        .in_left_valid       (s_tuser[0]),
        .in_right_char       (s_tdata[31:16]),
        .in_right_valid      (s_tuser[1]),
        .m_tready            (m_tready),
        .status              (status),
        .out_left_is_less    (left_is_less),
        .out_length_overflow (length_overflow)
    );

    // result register drives the output transfer directly
    assign m_tvalid = status.out_valid;
    assign m_tdata  = {7'd0, left_is_less};
    assign m_tuser  = length_overflow;

`ifndef NO_ASSERTIONS
    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished comparison not presented");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_tvalid)
        else $error("result overwrites an untaken result");

    a_last_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> (!m_tvalid || m_tready))
        else $error("final transfer taken while result register busy");
`endif

endmodule
